@@ rtl/mslm_pkg.sv @@
// Package for the MAC statistics table with LRU replacement.
// Holds table sizing, entry layout and state codes; no dependencies.
`default_nettype none
package mslm_pkg;
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic signed [7:0] RSSI_NONE_HI = -8'sd100;

    // key 48, pk 32, tx 32, rx 32, ss 32, sq 64, rssi 24, rate 16, seen 32, range 16
    localparam int ENTRY_W = 328;

    typedef struct packed {
        logic [47:0] key;
        logic [31:0] pk;
        logic [31:0] tx;
        logic [31:0] rx;
        logic [31:0] ss;
        logic [63:0] sq;
        logic [7:0]  rmax;
        logic [7:0]  rmin;
        logic [7:0]  rlat;
        logic [15:0] rate;
        logic [31:0] seen;
        logic [15:0] range;
    } entry_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_LAST  = 6'b000100,
        ST_READ  = 6'b001000,
        ST_MERGE = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;
endpackage
`default_nettype wire

@@ rtl/mslm_ram.sv @@
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module mslm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ rtl/mac_stats_table_lru_merge_top.sv @@
// MAC statistics table top level: scan sequencer, merge logic, result strobe.
// Depends on mslm_pkg and mslm_ram.
//
// In one transaction the table RAM is read one entry per cycle over every
// slot, looking for the key among occupied slots and the oldest last-seen time
// together, then the chosen slot is read again, merged and written back. busy is
// high from the accepting edge through the done cycle, and a new start is
// taken the cycle after done; the result is shown for one cycle with done and
// cannot be stalled.
`default_nettype none
module mac_stats_table_lru_merge_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [47:0]        mac_address,
    input  wire logic [31:0]        packet_count,
    input  wire logic [31:0]        sent_bytes,
    input  wire logic [31:0]        received_bytes,
    input  wire logic [31:0]        frame_size_sum,
    input  wire logic [63:0]        frame_size_sq_sum,
    input  wire logic signed [7:0]  latest_rssi,
    input  wire logic signed [7:0]  window_rssi_low,
    input  wire logic signed [7:0]  window_rssi_high,
    input  wire logic [15:0]        phy_rate,
    input  wire logic [31:0]        seen_timestamp,
    input  wire logic [15:0]        raw_range,
    output logic                    done,
    output logic [5:0]              slot_index,
    output logic                    was_hit,
    output logic                    was_evicted,
    output logic [32:0]             evicted_traffic,
    output logic [63:0]             evicted_traffic_total,
    output logic [15:0]             range_now
);
    localparam int IW = mslm_pkg::IDX_W;
    localparam int CW = mslm_pkg::CNT_W;

    mslm_pkg::state_t state_reg, state_next;
    mslm_pkg::entry_t in_reg, rd_ent, wr_ent;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] idx_reg, idx_next;      // scan read address
    logic [IW-1:0] chk_reg, chk_next;      // index of entry now on rdata
    logic [IW-1:0] slot_reg, slot_next;
    logic [IW-1:0] old_reg, old_next;
    logic [31:0]   oldt_reg, oldt_next;
    logic          hit_reg, hit_next;
    logic          ev_reg, ev_next;
    logic [32:0]   etr_reg, etr_next;
    logic [63:0]   sum_reg, sum_next;
    logic [15:0]   rng_reg, rng_next;
    logic [15:0]   div_q;
    logic [18:0]   div_num;
    logic          we;
    logic [IW-1:0] raddr;
    logic          chk_valid;

    mslm_ram #(.WIDTH(mslm_pkg::ENTRY_W), .DEPTH(mslm_pkg::TABLE_DEPTH)) u_tbl (
        .clk   (clk),
        .we    (we),
        .waddr (slot_reg),
        .wdata (wr_ent),
        .raddr (raddr),
        .rdata (rd_ent)
    );

    assign busy = (state_reg != mslm_pkg::ST_IDLE);
    assign chk_valid = ({1'b0, chk_reg} < count_reg);

    always_comb
    begin
        case (state_reg)
            mslm_pkg::ST_IDLE:
            begin
                raddr = '0;
            end
            mslm_pkg::ST_LAST:
            begin
                raddr = slot_next;
            end
            mslm_pkg::ST_READ:
            begin
                raddr = slot_reg;
            end
            default:
            begin
                raddr = idx_reg;
            end
        endcase
    end

    // floor(x/5) for x < 2^19 by reciprocal: x*419431 >> 21, exact below 699050
    always_comb
    begin
        logic [37:0] p;
        div_num = {3'b000, in_reg.range} + {1'b0, rd_ent.range, 2'b00};
        p = 38'(div_num) * 38'd419431;
        div_q = p[36:21];
    end

    always_comb
    begin
        logic signed [7:0] smin, smax;
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        chk_next   = chk_reg;
        slot_next  = slot_reg;
        old_next   = old_reg;
        oldt_next  = oldt_reg;
        hit_next   = hit_reg;
        ev_next    = ev_reg;
        etr_next   = etr_reg;
        sum_next   = sum_reg;
        rng_next   = rng_reg;
        we         = 1'b0;
        wr_ent     = in_reg;
        smin       = '0;
        smax       = '0;
        case (state_reg)
            mslm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = mslm_pkg::ST_SCAN;
                    idx_next   = IW'(1);
                    chk_next   = '0;
                    hit_next   = 1'b0;
                    ev_next    = 1'b0;
                    old_next   = '0;
                    oldt_next  = 32'hFFFF_FFFF;
                    etr_next   = '0;
                end
            end
            mslm_pkg::ST_SCAN, mslm_pkg::ST_LAST:
            begin
                if (chk_valid && !hit_reg && rd_ent.key == in_reg.key)
                begin
                    hit_next  = 1'b1;
                    slot_next = chk_reg;
                end
                if (rd_ent.seen < oldt_reg)
                begin
                    oldt_next = rd_ent.seen;
                    old_next  = chk_reg;
                end
                chk_next = chk_reg + IW'(1);
                idx_next = idx_reg + IW'(1);
                if (state_reg == mslm_pkg::ST_LAST)
                begin
                    state_next = mslm_pkg::ST_READ;
                    if (!hit_next)
                    begin
                        if (count_reg < CW'(mslm_pkg::TABLE_DEPTH))
                        begin
                            slot_next = count_reg[IW-1:0];
                        end
                        else
                        begin
                            slot_next = old_next;
                            ev_next   = 1'b1;
                        end
                    end
                end
                else if (chk_reg == IW'(mslm_pkg::TABLE_DEPTH - 2))
                begin
                    state_next = mslm_pkg::ST_LAST;
                end
            end
            mslm_pkg::ST_READ:
            begin
                state_next = mslm_pkg::ST_MERGE;
            end
            mslm_pkg::ST_MERGE:
            begin
                we = 1'b1;
                if (hit_reg)
                begin
                    wr_ent     = rd_ent;
                    wr_ent.pk  = rd_ent.pk + in_reg.pk;
                    wr_ent.tx  = rd_ent.tx + in_reg.tx;
                    wr_ent.rx  = rd_ent.rx + in_reg.rx;
                    wr_ent.ss  = rd_ent.ss + in_reg.ss;
                    wr_ent.sq  = rd_ent.sq + in_reg.sq;
                    if (in_reg.rate != '0)
                    begin
                        wr_ent.rate = in_reg.rate;
                    end
                    wr_ent.seen = in_reg.seen;
                    wr_ent.rlat = in_reg.rlat;
                    smin = signed'(rd_ent.rmin);
                    smax = signed'(rd_ent.rmax);
                    if (in_reg.rmin != '0 &&
                        (signed'(in_reg.rmin) < smin || smin == '0))
                    begin
                        wr_ent.rmin = in_reg.rmin;
                    end
                    if (signed'(in_reg.rmax) != mslm_pkg::RSSI_NONE_HI &&
                        (signed'(in_reg.rmax) > smax || smax == '0))
                    begin
                        wr_ent.rmax = in_reg.rmax;
                    end
                    if (in_reg.range != '0)
                    begin
                        wr_ent.range = div_q;
                    end
                end
                else
                begin
                    if (ev_reg)
                    begin
                        etr_next = {1'b0, rd_ent.tx} + {1'b0, rd_ent.rx};
                        sum_next = sum_reg + 64'(etr_next);
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
                rng_next   = wr_ent.range;
                state_next = mslm_pkg::ST_DONE;
            end
            mslm_pkg::ST_DONE:
            begin
                state_next = mslm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mslm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mslm_pkg::ST_IDLE;
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        chk_reg      <= chk_next;
        slot_reg     <= slot_next;
        old_reg      <= old_next;
        oldt_reg     <= oldt_next;
        hit_reg      <= hit_next;
        ev_reg       <= ev_next;
        etr_reg      <= etr_next;
        rng_reg      <= rng_next;
        if (state_reg == mslm_pkg::ST_IDLE && start)
        begin
            in_reg.key   <= mac_address;
            in_reg.pk    <= packet_count;
            in_reg.tx    <= sent_bytes;
            in_reg.rx    <= received_bytes;
            in_reg.ss    <= frame_size_sum;
            in_reg.sq    <= frame_size_sq_sum;
            in_reg.rlat  <= latest_rssi;
            in_reg.rmin  <= window_rssi_low;
            in_reg.rmax  <= window_rssi_high;
            in_reg.rate  <= phy_rate;
            in_reg.seen  <= seen_timestamp;
            in_reg.range <= raw_range;
        end
    end

    assign done                  = (state_reg == mslm_pkg::ST_DONE);
    assign slot_index            = 6'(slot_reg);
    assign was_hit               = hit_reg;
    assign was_evicted           = ev_reg;
    assign evicted_traffic       = etr_reg;
    assign evicted_traffic_total = sum_reg;
    assign range_now             = rng_reg;
endmodule
`default_nettype wire

@@ rtl/mslm_checker.sv @@
// Port-level checker for mac_stats_table_lru_merge_top, bound to the top level.
// Depends on the top level's ports only.
`default_nettype none
module mslm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic        was_hit,
    input wire logic        was_evicted,
    input wire logic [32:0] evicted_traffic,
    input wire logic [63:0] evicted_traffic_total
);
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("done outside transaction");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("accept did not raise busy");
    a_hit_ev: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(was_hit && was_evicted)) else $error("hit and evict");
    a_no_ev_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !was_evicted) |-> evicted_traffic == '0)
        else $error("traffic without eviction");
    a_total_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !was_evicted) |-> evicted_traffic_total == $past(evicted_traffic_total))
        else $error("total moved without eviction");
endmodule

bind mac_stats_table_lru_merge_top mslm_checker u_mslm_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .done                  (done),
    .was_hit               (was_hit),
    .was_evicted           (was_evicted),
    .evicted_traffic       (evicted_traffic),
    .evicted_traffic_total (evicted_traffic_total)
);
`default_nettype wire

@@ verif/mac_stats_table_lru_merge_top_test.sv @@
// Self-checking testbench for mac_stats_table_lru_merge_top: directed table then random records,
// each result compared against an in-bench table model. Depends on mslm_pkg and the RTL.
`default_nettype none
module mac_stats_table_lru_merge_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [47:0] mac;
        logic [31:0] pk, tx, rx, ss;
        logic [63:0] sq;
        logic signed [7:0] lat, wlo, whi;
        logic [15:0] rate;
        logic [31:0] seen;
        logic [15:0] raw;
    } record_t;

    typedef struct {
        logic [5:0] slot;
        logic hit, evict;
        logic [32:0] etraffic;
        logic [63:0] etotal;
        logic [15:0] range_v;
        logic known;
    } merge_result_t;

    logic clk = 0, rst_n = 0, start = 0;
    logic busy, done;
    logic [47:0] mac_address = '0;
    logic [31:0] packet_count = '0, sent_bytes = '0, received_bytes = '0, frame_size_sum = '0;
    logic [63:0] frame_size_sq_sum = '0;
    logic signed [7:0] latest_rssi = '0, window_rssi_low = '0, window_rssi_high = '0;
    logic [15:0] phy_rate = '0, raw_range = '0;
    logic [31:0] seen_timestamp = '0;
    logic [5:0] slot_index;
    logic was_hit, was_evicted;
    logic [32:0] evicted_traffic;
    logic [63:0] evicted_traffic_total;
    logic [15:0] range_now;

    mac_stats_table_lru_merge_top dut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // table model
    int unsigned n_entries;
    logic [63:0] evicted_total;
    record_t tbl [mslm_pkg::TABLE_DEPTH];
    merge_result_t pending_results[$];
    int errors = 0;
    logic [47:0] mac_pool [16];

    function automatic merge_result_t merge_record(record_t r);
        merge_result_t res;
        int slot = 0;
        logic [31:0] oldest;
        res = '{default: '0};
        res.known = 0;
        for (int i = 0; i < n_entries; i++)
        begin
            if (tbl[i].mac == r.mac && !res.hit)
            begin
                slot = i;
                res.hit = 1;
            end
        end
        if (res.hit)
        begin
            tbl[slot].pk += r.pk;
            tbl[slot].tx += r.tx;
            tbl[slot].rx += r.rx;
            tbl[slot].ss += r.ss;
            tbl[slot].sq += r.sq;
            if (r.rate != 0) tbl[slot].rate = r.rate;
            tbl[slot].seen = r.seen;
            tbl[slot].lat = r.lat;
            if (r.wlo != 0 && (r.wlo < tbl[slot].wlo || tbl[slot].wlo == 0))
                tbl[slot].wlo = r.wlo;
            if (r.whi != mslm_pkg::RSSI_NONE_HI &&
                (r.whi > tbl[slot].whi || tbl[slot].whi == 0))
                tbl[slot].whi = r.whi;
            if (r.raw != 0)
                tbl[slot].raw = 16'((32'(r.raw) + 4 * 32'(tbl[slot].raw)) / 5);
        end
        else
        begin
            if (n_entries < mslm_pkg::TABLE_DEPTH)
            begin
                slot = n_entries;
                n_entries++;
            end
            else
            begin
                oldest = '1;
                for (int i = 0; i < mslm_pkg::TABLE_DEPTH; i++)
                begin
                    if (tbl[i].seen < oldest)
                    begin
                        oldest = tbl[i].seen;
                        slot = i;
                    end
                end
                res.evict = 1;
                res.etraffic = 33'(tbl[slot].tx) + 33'(tbl[slot].rx);
                evicted_total += 64'(res.etraffic);
            end
            tbl[slot] = r;
        end
        res.slot = 6'(slot);
        res.etotal = evicted_total;
        res.range_v = tbl[slot].raw;
        return res;
    endfunction

    task automatic send_record(record_t r, merge_result_t typed);
        merge_result_t res;
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 80) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(posedge clk);
        while (busy || start) @(posedge clk);
        res = merge_record(r);
        if (typed.known)
        begin
            if (typed.slot != res.slot || typed.hit != res.hit || typed.evict != res.evict ||
                typed.etraffic != res.etraffic || typed.range_v != res.range_v)
            begin
                $error("directed row disagrees with table model, slot %0d", res.slot);
                errors++;
            end
        end
        pending_results.push_back(res);
        start <= 1;
        mac_address <= r.mac;
        packet_count <= r.pk;
        sent_bytes <= r.tx;
        received_bytes <= r.rx;
        frame_size_sum <= r.ss;
        frame_size_sq_sum <= r.sq;
        latest_rssi <= r.lat;
        window_rssi_low <= r.wlo;
        window_rssi_high <= r.whi;
        phy_rate <= r.rate;
        seen_timestamp <= r.seen;
        raw_range <= r.raw;
        @(posedge clk);
        start <= 0;
    endtask

    always @(posedge clk)
    begin
        merge_result_t e;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no transaction outstanding");
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (slot_index !== e.slot)
                begin
                    $error("slot_index exp %0d got %0d", e.slot, slot_index);
                    errors++;
                end
                if (was_hit !== e.hit)
                begin
                    $error("was_hit exp %0d got %0d", e.hit, was_hit);
                    errors++;
                end
                if (was_evicted !== e.evict)
                begin
                    $error("was_evicted exp %0d got %0d", e.evict, was_evicted);
                    errors++;
                end
                if (evicted_traffic !== e.etraffic)
                begin
                    $error("evicted_traffic exp %0h got %0h", e.etraffic, evicted_traffic);
                    errors++;
                end
                if (evicted_traffic_total !== e.etotal)
                begin
                    $error("evicted_traffic_total exp %0h got %0h", e.etotal,
                           evicted_traffic_total);
                    errors++;
                end
                if (range_now !== e.range_v)
                begin
                    $error("range_now exp %0h got %0h", e.range_v, range_now);
                    errors++;
                end
            end
        end
    end

    function automatic record_t rand_record(logic [47:0] mac);
        record_t r;
        r.mac = mac;
        r.pk = $urandom;
        r.tx = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 9) : $urandom;
        r.rx = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 9) : $urandom;
        r.ss = $urandom;
        r.sq = {$urandom, $urandom};
        r.lat = $urandom;
        case ($urandom_range(0, 3))
            0: r.wlo = 0;
            1: r.wlo = -8'sd128 + $urandom_range(0, 127);
            default: r.wlo = $urandom;
        endcase
        case ($urandom_range(0, 3))
            0: r.whi = mslm_pkg::RSSI_NONE_HI;
            1: r.whi = 0;
            default: r.whi = $urandom;
        endcase
        r.rate = ($urandom_range(0, 3) == 0) ? 16'h0 : 16'($urandom);
        case ($urandom_range(0, 5))
            0: r.seen = 32'hFFFF_FFFF;
            1: r.seen = $urandom_range(0, 20);
            default: r.seen = $urandom;
        endcase
        r.raw = ($urandom_range(0, 3) == 0) ? 16'h0 : 16'($urandom);
        return r;
    endfunction

    initial
    begin
        #20ms;
        $display("FAIL mac_stats_table_lru_merge_top");
        $finish;
    end

    initial
    begin
        record_t dir_rows [$];
        merge_result_t dir_exp [$];
        record_t r;
        merge_result_t none;
        int phase_len;
        none = '{default: '0};
        n_entries = 0;
        evicted_total = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, sentinels, smoothing, all-max eviction of slot 0
        r = '{mac: '1, pk: '1, tx: '1, rx: '1, ss: '1, sq: '1, lat: 127, wlo: -128,
              whi: 127, rate: '1, seen: '1, raw: '1};
        dir_rows.push_back(r);
        dir_exp.push_back('{slot: 0, hit: 0, evict: 0, etraffic: 0, etotal: 0,
                            range_v: 16'hFFFF, known: 1});
        r = '{mac: '1, pk: 1, tx: 1, rx: 1, ss: 1, sq: 1, lat: -128, wlo: 0,
              whi: mslm_pkg::RSSI_NONE_HI, rate: 0, seen: '1, raw: 0};
        dir_rows.push_back(r);
        dir_exp.push_back('{slot: 0, hit: 1, evict: 0, etraffic: 0, etotal: 0,
                            range_v: 16'hFFFF, known: 1});
        r = '{mac: 0, pk: 0, tx: 0, rx: 0, ss: 0, sq: 0, lat: 0, wlo: 0, whi: 0,
              rate: 0, seen: '1, raw: 0};
        dir_rows.push_back(r);
        dir_exp.push_back('{slot: 1, hit: 0, evict: 0, etraffic: 0, etotal: 0,
                            range_v: 0, known: 1});
        r.wlo = -5; r.whi = -90; r.raw = 16'h0500;
        dir_rows.push_back(r);
        dir_exp.push_back('{slot: 1, hit: 1, evict: 0, etraffic: 0, etotal: 0,
                            range_v: 16'h0100, known: 1});
        r.wlo = -70; r.whi = -100; r.raw = 1;
        dir_rows.push_back(r);
        dir_exp.push_back(none);
        r.wlo = 10; r.whi = 20; r.raw = 16'hFFFF;
        dir_rows.push_back(r);
        dir_exp.push_back(none);
        for (int i = 2; i < mslm_pkg::TABLE_DEPTH; i++)
        begin
            r = rand_record(48'h1000 + i);
            r.seen = '1;
            dir_rows.push_back(r);
            dir_exp.push_back(none);
        end
        // slot 0 tx and rx both wrapped to zero
        r = rand_record(48'hABCD);
        dir_rows.push_back(r);
        dir_exp.push_back('{slot: 0, hit: 0, evict: 1, etraffic: 0,
                            etotal: 0, range_v: r.raw, known: 1});
        foreach (dir_rows[k])
            send_record(dir_rows[k], dir_exp[k]);

        for (int i = 0; i < 16; i++)
            mac_pool[i] = {$urandom, $urandom};
        for (int n = 0; n < 1280; n++)
        begin
            phase_len = $urandom_range(0, 9);
            if (phase_len < 5)
                r = rand_record(mac_pool[$urandom_range(0, 15)]);
            else if (phase_len < 7 && n_entries > 0)
                r = rand_record(tbl[$urandom_range(0, n_entries - 1)].mac);
            else
                r = rand_record({$urandom, $urandom});
            send_record(r, none);
        end

        while (pending_results.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        if (errors == 0)
            $display("PASS mac_stats_table_lru_merge_top");
        else
            $display("FAIL mac_stats_table_lru_merge_top");
        $finish;
    end
endmodule
`default_nettype wire
